// ===== rtl/bfg_pkg.sv =====
// bfg_pkg: shared constants, types and the decimal digit adder of the
// bcd fibonacci generator; no dependencies
package bfg_pkg;

  // digit positions per store
  localparam int unsigned DIGITS = 256;
  localparam int unsigned ADDR_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned CNT_W  = $clog2(DIGITS + 1);

  // payload widths fixed by the interface
  localparam int unsigned ORD_W   = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned DCOUNT_W = 9;

  typedef logic [3:0]        digit_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [0:0] {
    REQ_COMPUTE = 1'b0,
    REQ_READ    = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_PREP,
    ST_ADD,
    ST_RDATA,
    ST_DONE
  } state_e;

  // one write port of a digit store
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    digit_t wdata;
  } mem_wr_t;

  // finished result handed to the output register
  typedef struct packed {
    logic                valid;
    digit_t              digit_value;
    logic [DCOUNT_W-1:0] digit_count;
    logic                overflow;
    logic [ORD_W-1:0]    ordinal_reached;
  } res_t;

  // one decimal digit add: returns {carry, digit}
  function automatic logic [4:0] bcd_add_digit(digit_t a, digit_t b, logic cin);
    logic [4:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {4'b0, cin};
    if (sum > 5'd9) begin
      return {1'b1, 4'(sum - 5'd10)};
    end
    return {1'b0, sum[3:0]};
  endfunction

endpackage

// ===== rtl/bfg_if.sv =====
// bfg_req_if / bfg_rsp_if: valid-ready channels of the bcd fibonacci generator
// depends on bfg_pkg
interface bfg_req_if;
  import bfg_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [ORD_W-1:0] ordinal;
  logic [IDX_W-1:0] digit_index;

  modport source (output valid, req_type, ordinal, digit_index, input ready);
  modport sink   (input valid, req_type, ordinal, digit_index, output ready);
endinterface

interface bfg_rsp_if;
  import bfg_pkg::*;
  logic                valid;
  logic                ready;
  logic [3:0]          digit_value;
  logic [DCOUNT_W-1:0] digit_count;
  logic                overflow;
  logic [ORD_W-1:0]    ordinal_reached;

  modport source (output valid, digit_value, digit_count, overflow, ordinal_reached,
                  input ready);
  modport sink   (input valid, digit_value, digit_count, overflow, ordinal_reached,
                  output ready);
endinterface

// ===== rtl/bfg_digit_ram.sv =====
// bfg_digit_ram: generic one-write one-read synchronous ram, registered read
// no dependencies
module bfg_digit_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 4
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/bfg_seq.sv =====
// bfg_seq: sequencer of the bcd fibonacci generator; walks the digit stores,
// runs the ripple decimal additions and forms each result; depends on bfg_pkg
module bfg_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      req_type_i,
  input  logic [bfg_pkg::ORD_W-1:0] ordinal_i,
  input  logic [bfg_pkg::IDX_W-1:0] digit_index_i,
  input  bfg_pkg::digit_t           rd_a_i,
  input  bfg_pkg::digit_t           rd_b_i,
  output logic                      idle_o,
  output bfg_pkg::addr_t            rd_addr_o,
  output bfg_pkg::mem_wr_t          wr_a_o,
  output bfg_pkg::mem_wr_t          wr_b_o,
  output bfg_pkg::res_t             res_o
);
  import bfg_pkg::*;

  state_e           state_q, state_d;
  cnt_t             lim_a_q, lim_a_d;     // entries below this are valid in store a
  cnt_t             lim_b_q, lim_b_d;
  logic             in_b_q, in_b_d;
  logic             ovf_q, ovf_d;
  logic [ORD_W-1:0] reached_q, reached_d;
  logic [ORD_W-1:0] ord_q, ord_d;
  logic             dst_b_q, dst_b_d;
  addr_t            pos_q, pos_d;
  cnt_t             len_q, len_d;
  logic             carry_q, carry_d;
  cnt_t             topnz_q, topnz_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  cnt_t             cnt_a, cnt_b, cnt_max, cnt_res;
  cnt_t             pos_ext, pos_p1, src_lim, dst_lim, topnz_new;
  digit_t           src_raw, dst_raw, src_v, dst_v, rd_sel, rd_masked;
  logic [4:0]       add_res;
  logic             last, ovf_now;
  logic [ORD_W-1:0] reached_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lim_a_q   <= '0;
      lim_b_q   <= '0;
      in_b_q    <= 1'b0;
      ovf_q     <= 1'b0;
      reached_q <= '0;
      ord_q     <= '0;
      dst_b_q   <= 1'b0;
      pos_q     <= '0;
      len_q     <= '0;
      carry_q   <= 1'b0;
      topnz_q   <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      lim_a_q   <= lim_a_d;
      lim_b_q   <= lim_b_d;
      in_b_q    <= in_b_d;
      ovf_q     <= ovf_d;
      reached_q <= reached_d;
      ord_q     <= ord_d;
      dst_b_q   <= dst_b_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      carry_q   <= carry_d;
      topnz_q   <= topnz_d;
      idx_q     <= idx_d;
    end
  end

  // datapath of one digit step
  always_comb begin
    cnt_a       = (lim_a_q == '0) ? cnt_t'(1) : lim_a_q;
    cnt_b       = (lim_b_q == '0) ? cnt_t'(1) : lim_b_q;
    cnt_max     = (cnt_a > cnt_b) ? cnt_a : cnt_b;
    cnt_res     = in_b_q ? cnt_b : cnt_a;
    pos_ext     = cnt_t'(pos_q);
    pos_p1      = pos_ext + cnt_t'(1);
    src_raw     = dst_b_q ? rd_a_i : rd_b_i;
    dst_raw     = dst_b_q ? rd_b_i : rd_a_i;
    src_lim     = dst_b_q ? lim_a_q : lim_b_q;
    dst_lim     = dst_b_q ? lim_b_q : lim_a_q;
    // entries past the valid limit stand for zero
    src_v       = (pos_ext < src_lim) ? src_raw : digit_t'(0);
    dst_v       = (pos_ext < dst_lim) ? dst_raw : digit_t'(0);
    add_res     = bcd_add_digit(src_v, dst_v, carry_q);
    topnz_new   = (add_res[3:0] != '0) ? pos_p1 : topnz_q;
    last        = (pos_p1 == len_q);
    ovf_now     = (len_q == cnt_t'(DIGITS)) && ((add_res[3:0] != '0) || add_res[4]);
    reached_inc = reached_q + ORD_W'(1);
    rd_sel      = in_b_q ? rd_b_i : rd_a_i;
    rd_masked   = (32'(idx_q) < 32'(in_b_q ? lim_b_q : lim_a_q)) ? rd_sel : digit_t'(0);
  end

  always_comb begin
    state_d   = state_q;
    lim_a_d   = lim_a_q;
    lim_b_d   = lim_b_q;
    in_b_d    = in_b_q;
    ovf_d     = ovf_q;
    reached_d = reached_q;
    ord_d     = ord_q;
    dst_b_d   = dst_b_q;
    pos_d     = pos_q;
    len_d     = len_q;
    carry_d   = carry_q;
    topnz_d   = topnz_q;
    idx_d     = idx_q;
    rd_addr_o = '0;
    wr_a_o    = '0;
    wr_b_o    = '0;
    res_o     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == REQ_READ) begin
            idx_d     = digit_index_i;
            rd_addr_o = addr_t'(digit_index_i);
            state_d   = ST_RDATA;
          end else begin
            ord_d     = ordinal_i;
            lim_a_d   = '0;
            lim_b_d   = cnt_t'(1);
            in_b_d    = 1'b0;
            ovf_d     = 1'b0;
            reached_d = '0;
            dst_b_d   = 1'b1;
            state_d   = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        // store b starts as one
        wr_b_o.we    = 1'b1;
        wr_b_o.waddr = '0;
        wr_b_o.wdata = digit_t'(1);
        state_d      = (ord_q == '0) ? ST_DONE : ST_PREP;
      end
      ST_PREP: begin
        len_d     = (32'(cnt_max) >= DIGITS) ? cnt_t'(DIGITS) : cnt_max + cnt_t'(1);
        pos_d     = '0;
        carry_d   = 1'b0;
        topnz_d   = '0;
        rd_addr_o = '0;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        wr_a_o.we    = !dst_b_q;
        wr_a_o.waddr = pos_q;
        wr_a_o.wdata = add_res[3:0];
        wr_b_o.we    = dst_b_q;
        wr_b_o.waddr = pos_q;
        wr_b_o.wdata = add_res[3:0];
        carry_d      = add_res[4];
        topnz_d      = topnz_new;
        if (last) begin
          if (dst_b_q) begin
            lim_b_d = topnz_new;
          end else begin
            lim_a_d = topnz_new;
          end
          in_b_d    = dst_b_q;
          reached_d = reached_inc;
          if (ovf_now || reached_inc == ord_q) begin
            ovf_d   = ovf_now;
            state_d = ST_DONE;
          end else begin
            dst_b_d = !dst_b_q;
            state_d = ST_PREP;
          end
        end else begin
          pos_d     = addr_t'(pos_p1);
          rd_addr_o = addr_t'(pos_p1);
        end
      end
      ST_RDATA: begin
        res_o.valid           = 1'b1;
        res_o.digit_value     = rd_masked;
        res_o.digit_count     = DCOUNT_W'(cnt_res);
        res_o.overflow        = ovf_q;
        res_o.ordinal_reached = reached_q;
        state_d               = ST_IDLE;
      end
      ST_DONE: begin
        res_o.valid           = 1'b1;
        res_o.digit_value     = '0;
        res_o.digit_count     = DCOUNT_W'(cnt_res);
        res_o.overflow        = ovf_q;
        res_o.ordinal_reached = reached_q;
        state_d               = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/bcd_fibonacci_generator_unit.sv =====
// bcd_fibonacci_generator_unit: top level of the decimal fibonacci generator
// depends on bfg_pkg, bfg_if, bfg_digit_ram and bfg_seq
//
// usage
// - req_i carries one request per beat: req_type 0 computes F(ordinal) into
//   the digit stores, req_type 1 reads digit digit_index of the last result
// - rsp_o returns exactly one beat per request: the digit (0 for a compute),
//   the digit count of the held number, the overflow flag and the ordinal held
// - one request is in flight at a time; req_i.ready is high only while the
//   sequencer is idle and the response register is empty or being drained
// - a read passes through ST_RDATA, which loads the response register
// - a compute runs ST_SEED, then per addition ST_PREP and len digit steps in ST_ADD,
//   where len is the longer operand's digit count plus one (capped at DIGITS); the
//   single write port of each digit store paces these steps, one digit per cycle
// - additions alternate between store a and store b; each store carries a valid
//   limit, and entries at or above it read as zero, so no clearing pass is run
//   after reset or at the start of a compute
// - if a sum fills the top digit position the compute stops, overflow is set
//   and ordinal_reached names the number actually held
// - after reset the held result reads as F(0) = 0 with digit count 1
// - a stalled response stays in the output register; no new request is taken
//   until it has been drained
module bcd_fibonacci_generator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfg_req_if.sink   req_i,
  bfg_rsp_if.source rsp_o
);
  import bfg_pkg::*;

  logic    seq_idle;
  logic    req_accept;
  addr_t   rd_addr;
  mem_wr_t wr_a, wr_b;
  digit_t  rd_a, rd_b;
  res_t    res;

  // response register
  logic                out_valid_q;
  digit_t              digit_value_q;
  logic [DCOUNT_W-1:0] digit_count_q;
  logic                overflow_q;
  logic [ORD_W-1:0]    reached_q;

  // take a request only when the previous response is gone or leaving now
  assign req_i.ready = seq_idle && (!out_valid_q || rsp_o.ready);
  assign req_accept  = req_i.valid && req_i.ready;

  bfg_digit_ram #(
    .DEPTH (DIGITS),
    .WIDTH (4)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (wr_a.we),
    .waddr_i (wr_a.waddr),
    .wdata_i (wr_a.wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_a)
  );

  bfg_digit_ram #(
    .DEPTH (DIGITS),
    .WIDTH (4)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (wr_b.we),
    .waddr_i (wr_b.waddr),
    .wdata_i (wr_b.wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_b)
  );

  bfg_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (req_accept),
    .req_type_i    (req_i.req_type),
    .ordinal_i     (req_i.ordinal),
    .digit_index_i (req_i.digit_index),
    .rd_a_i        (rd_a),
    .rd_b_i        (rd_b),
    .idle_o        (seq_idle),
    .rd_addr_o     (rd_addr),
    .wr_a_o        (wr_a),
    .wr_b_o        (wr_b),
    .res_o         (res)
  );

  // valid flag of the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload, loaded once per finished request
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      digit_value_q <= res.digit_value;
      digit_count_q <= res.digit_count;
      overflow_q    <= res.overflow;
      reached_q     <= res.ordinal_reached;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.digit_value     = digit_value_q;
  assign rsp_o.digit_count     = digit_count_q;
  assign rsp_o.overflow        = overflow_q;
  assign rsp_o.ordinal_reached = reached_q;

  // a finished result never lands on an undrained response
  a_res_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !out_valid_q)
    else $error("result produced while response register still full");

  // a request in flight blocks further requests
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // digits are decimal
  a_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (digit_value_q <= 4'd9))
    else $error("non-decimal digit in response");

  // an overflow stop always follows at least one addition
  a_ovf_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && overflow_q) |-> (reached_q != '0))
    else $error("overflow flagged with no addition done");

endmodule

// ===== dv/tb_bcd_fibonacci_generator_unit.sv =====
// tb_bcd_fibonacci_generator_unit: self-checking bench for the decimal fibonacci generator
// drives compute and digit-read requests, predicts every response beat and compares them
// depends on bfg_pkg, bfg_if and the rtl of bcd_fibonacci_generator_unit
`timescale 1ns / 100ps

module tb_bcd_fibonacci_generator_unit;
  import bfg_pkg::*;

  // cycles without any accepted beat before the run is declared hung;
  // the worst compute (overflow near ordinal 1222) must stay well inside it
  localparam int unsigned HANG_LIMIT = 700_000;
  // requests near the end that are sent with no idling on either side
  localparam int unsigned QUIET_TAIL = 15;
  // slack allowed after the last response
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    req_e             kind;
    logic [ORD_W-1:0] ordinal;
    logic [IDX_W-1:0] digit_index;
    bit               drain_first;  // hold this beat until no response is owed
  } req_beat_t;

  typedef struct packed {
    digit_t              digit_value;
    logic [DCOUNT_W-1:0] digit_count;
    logic                overflow;
    logic [ORD_W-1:0]    ordinal_reached;
  } rsp_beat_t;

  logic clk_i;
  logic rst_ni;

  bfg_req_if req_if ();
  bfg_rsp_if rsp_if ();

  bcd_fibonacci_generator_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // request beats still to be sent, and response beats owed by the block
  req_beat_t pending_req_q[$];
  rsp_beat_t owed_rsp_q[$];

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned recv_stall;
  bit          req_taken;
  bit          quiet_tail;

  // ---------------------------------------------------------------------------
  // predictor: two ping-pong digit stores, least significant digit at index 0
  // ---------------------------------------------------------------------------
  digit_t           fib_a[DIGITS];
  digit_t           fib_b[DIGITS];
  int unsigned      len_a;
  int unsigned      len_b;
  bit               held_in_b;
  bit               stopped_full;
  logic [ORD_W-1:0] held_ordinal;

  function automatic void clear_stores();
    for (int unsigned p = 0; p < DIGITS; p++) begin
      fib_a[p] = '0;
      fib_b[p] = '0;
    end
    len_a        = 1;
    len_b        = 1;
    held_in_b    = 1'b0;
    stopped_full = 1'b0;
    held_ordinal = '0;
  endfunction

  // adds one store into the other digit by digit; returns 1 when the sum
  // reaches the top position or a carry falls off the end
  function automatic bit add_stores(bit into_b);
    int unsigned span;
    int unsigned top_used;
    logic [4:0]  sum;
    bit          carry;
    digit_t      x;
    digit_t      y;

    span     = ((len_a > len_b) ? len_a : len_b) + 1;
    if (span > DIGITS) span = DIGITS;
    top_used = 0;
    carry    = 1'b0;
    for (int unsigned p = 0; p < span; p++) begin
      x   = into_b ? fib_a[p] : fib_b[p];
      y   = into_b ? fib_b[p] : fib_a[p];
      sum = {1'b0, x} + {1'b0, y} + {4'b0, carry};
      // decimal correction
      if (sum > 5'd9) begin
        sum   = sum - 5'd10;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      if (into_b) fib_b[p] = sum[3:0];
      else        fib_a[p] = sum[3:0];
      if (sum != 5'd0) top_used = p + 1;
    end
    if (into_b) len_b = (top_used == 0) ? 1 : top_used;
    else        len_a = (top_used == 0) ? 1 : top_used;
    if (into_b) return (fib_b[DIGITS-1] != 4'd0) || (carry && span == DIGITS);
    return (fib_a[DIGITS-1] != 4'd0) || (carry && span == DIGITS);
  endfunction

  // works out the response beat that one accepted request must produce
  function automatic rsp_beat_t fib_response_for(req_beat_t r);
    rsp_beat_t   rsp;
    int unsigned cnt;
    bit          full;

    rsp = '0;
    if (r.kind == REQ_COMPUTE) begin
      clear_stores();
      fib_b[0] = 4'd1;  // seed: a holds F(0), b holds F(1)
      for (int unsigned j = 0; j < r.ordinal; j++) begin
        full         = add_stores(j[0] == 1'b0);
        held_in_b    = (j[0] == 1'b0);
        held_ordinal = ORD_W'(j + 1);
        if (full) begin
          stopped_full = 1'b1;
          break;
        end
      end
    end else if (r.digit_index < DIGITS) begin
      rsp.digit_value = held_in_b ? fib_b[r.digit_index] : fib_a[r.digit_index];
    end
    cnt                 = held_in_b ? len_b : len_a;
    rsp.digit_count     = cnt[DCOUNT_W-1:0];
    rsp.overflow        = stopped_full;
    rsp.ordinal_reached = held_ordinal;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_compute(logic [ORD_W-1:0] ord, bit drain);
    req_beat_t r;
    r.kind        = REQ_COMPUTE;
    r.ordinal     = ord;
    r.digit_index = IDX_W'($urandom);  // don't-care field, keep it toggling
    r.drain_first = drain;
    pending_req_q.push_back(r);
  endfunction

  function automatic void queue_read(logic [IDX_W-1:0] idx);
    req_beat_t r;
    r.kind        = REQ_READ;
    r.ordinal     = ORD_W'($urandom);   // ignored by a read
    r.digit_index = idx;
    r.drain_first = 1'b0;
    pending_req_q.push_back(r);
  endfunction

  // most computes stay small so the run stays short; a few go all the way
  function automatic logic [ORD_W-1:0] pick_ordinal();
    int unsigned pick;
    pick = $urandom_range(0, 49);
    if (pick == 0) return ORD_W'($urandom_range(0, 65535));
    if (pick <= 6) return ORD_W'($urandom_range(0, 600));
    return ORD_W'($urandom_range(0, 120));
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // request driver: changes inputs on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_req
    req_beat_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      // beat offered but not yet taken: hold it steady
    end else if (send_gap > 0) begin
      send_gap--;
      req_if.valid <= 1'b0;
    end else if (pending_req_q.size() == 0 ||
                 (pending_req_q[0].drain_first && owed_rsp_q.size() != 0)) begin
      req_if.valid <= 1'b0;
    end else begin
      nxt = pending_req_q.pop_front();
      req_if.valid       <= 1'b1;
      req_if.req_type    <= nxt.kind;
      req_if.ordinal     <= nxt.ordinal;
      req_if.digit_index <= nxt.digit_index;
      // idle burst after this beat
      if (!quiet_tail && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
    end
  end

  // ---------------------------------------------------------------------------
  // response sink: random stall bursts of ready-low cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (quiet_tail) begin
      rsp_if.ready <= 1'b1;
    end else if (recv_stall > 0) begin
      recv_stall--;
      rsp_if.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(0, 9);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge, checks responses
  // against the oldest owed beat and records what each new request owes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_beats
    req_beat_t seen_req;
    rsp_beat_t got;
    rsp_beat_t exp;
    bit        rsp_taken;
    if (rst_ni) begin
      req_taken  = req_if.valid && req_if.ready;
      rsp_taken  = rsp_if.valid && rsp_if.ready;
      quiet_tail = (pending_req_q.size() <= QUIET_TAIL);

      if (rsp_taken) begin
        got.digit_value     = rsp_if.digit_value;
        got.digit_count     = rsp_if.digit_count;
        got.overflow        = rsp_if.overflow;
        got.ordinal_reached = rsp_if.ordinal_reached;
        if (owed_rsp_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: response beat with no request outstanding: digit %0d count %0d",
                     $realtime, got.digit_value, got.digit_count);
        end else begin
          exp = owed_rsp_q.pop_front();
          if (got.digit_value !== exp.digit_value || got.digit_count !== exp.digit_count ||
              got.overflow !== exp.overflow || got.ordinal_reached !== exp.ordinal_reached)
              begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: mismatch exp digit %0d count %0d ovf %0b ord %0d", $realtime,
                       exp.digit_value, exp.digit_count, exp.overflow, exp.ordinal_reached);
              $display("%0t:          got digit %0d count %0d ovf %0b ord %0d", $realtime,
                       got.digit_value, got.digit_count, got.overflow, got.ordinal_reached);
            end
          end
        end
      end

      if (req_taken) begin
        seen_req.kind        = req_e'(req_if.req_type);
        seen_req.ordinal     = req_if.ordinal;
        seen_req.digit_index = req_if.digit_index;
        seen_req.drain_first = 1'b0;
        owed_rsp_q.push_back(fib_response_for(seen_req));
      end

      // hang detection: a long compute is the only legal quiet stretch
      if (req_taken || rsp_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= HANG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned       sent;
    int unsigned       shape;
    int unsigned       reads;
    logic [ORD_W-1:0]  ord;
    int unsigned       idx_top;

    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_COMPUTE;
    req_if.ordinal     = '0;
    req_if.digit_index = '0;
    rsp_if.ready       = 1'b0;
    error_count        = 0;
    idle_cycles        = 0;
    send_gap           = 0;
    recv_stall         = 0;
    req_taken          = 1'b0;
    quiet_tail         = 1'b0;
    clear_stores();

    // directed: reads straight after reset see F(0)
    queue_read(8'd0);
    queue_read(8'd255);
    // zero ordinal, then the two seed values
    queue_compute(16'd0, 1'b0);
    queue_read(8'd0);
    queue_compute(16'd1, 1'b0);
    queue_read(8'd0);
    queue_compute(16'd2, 1'b0);
    // F(12) = 144: three digits, then a position past the count
    queue_compute(16'd12, 1'b0);
    queue_read(8'd0);
    queue_read(8'd1);
    queue_read(8'd2);
    queue_read(8'd3);
    // largest ordinal: stops when the store fills; sender waits for the drain first
    queue_compute(16'hFFFF, 1'b1);
    queue_read(8'd255);
    queue_read(8'd254);
    queue_read(8'd0);
    // the last number that still fits below the top position
    queue_compute(16'd1221, 1'b1);
    queue_read(8'd254);
    queue_read(8'd255);
    queue_read(8'd128);

    // random: mostly a compute followed by reads inside the number,
    // with some stray reads and back-to-back computes mixed in
    sent = 0;
    while (sent < 80) begin
      shape = $urandom_range(0, 19);
      if (shape < 2) begin
        queue_read(IDX_W'($urandom_range(0, 255)));
        sent++;
      end else if (shape < 4) begin
        queue_compute(pick_ordinal(), 1'b0);
        queue_compute(pick_ordinal(), $urandom_range(0, 9) == 0);
        sent += 2;
      end else begin
        ord = pick_ordinal();
        queue_compute(ord, $urandom_range(0, 9) == 0);
        idx_top = ord / 4 + 2;
        if (idx_top > 255) idx_top = 255;
        reads = $urandom_range(1, 5);
        for (int unsigned k = 0; k < reads; k++) begin
          if ($urandom_range(0, 4) == 0) queue_read(IDX_W'($urandom_range(0, 255)));
          else                           queue_read(IDX_W'($urandom_range(0, idx_top)));
        end
        sent += reads + 1;
      end
    end

    // single reset at the start of the run
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait until every request is taken and every response has come back
    while (pending_req_q.size() != 0 || req_if.valid || owed_rsp_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    error_count += owed_rsp_q.size();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
